@@ sv/svf_pkg.sv @@
// Shared widths, register indexes and controller command type for the fade block.
`timescale 1ns / 1ps

package svf_pkg;

  // Field and register widths
  localparam int unsigned SampleW = 16;
  localparam int unsigned VolW    = 16;
  localparam int unsigned PosW    = 40;
  localparam int unsigned FracW   = 16;
  localparam int unsigned CfgIdxW = 2;
  localparam int unsigned CfgW    = 40;
  localparam int unsigned DivCntW = $clog2(FracW);

  // Configuration register indexes
  localparam logic [CfgIdxW-1:0] RegVolume = 2'd0;
  localparam logic [CfgIdxW-1:0] RegFadeStart = 2'd1;
  localparam logic [CfgIdxW-1:0] RegTotal = 2'd2;
  localparam logic [CfgIdxW-1:0] RegLoop = 2'd3;

  // Controller to datapath commands, at most one high per cycle
  typedef struct packed {
    logic load_in;   // capture an accepted request
    logic prep_pos;  // end-of-track check, remainder load, volume product
    logic prep_len;  // fade length, fade decision, position advance
    logic div_step;  // one quotient bit of the fade fraction
    logic mul_frac;  // apply fade fraction
    logic load_out;  // saturate and fill the output register
  } svf_cmd_t;

endpackage

@@ sv/svf_ctrl.sv @@
// Sequencing state machine and output valid flag of the fade block.
`timescale 1ns / 1ps

module svf_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output svf_pkg::svf_cmd_t cmd_o
);

  localparam logic [2:0] StIdle    = 3'd0;
  localparam logic [2:0] StPrepPos = 3'd1;
  localparam logic [2:0] StPrepLen = 3'd2;
  localparam logic [2:0] StDiv     = 3'd3;
  localparam logic [2:0] StMul     = 3'd4;
  localparam logic [2:0] StFinish  = 3'd5;

  localparam logic [svf_pkg::DivCntW-1:0] DivLast = svf_pkg::DivCntW'(svf_pkg::FracW - 1);

  logic [2:0]                  state_q, state_d;
  logic [svf_pkg::DivCntW-1:0] cnt_q, cnt_d;
  logic                        ovalid_q, ovalid_d;
  logic                        out_free;

  assign out_free    = !ovalid_q || out_ready_i;
  assign in_ready_o  = (state_q == StIdle);
  assign out_valid_o = ovalid_q;

  // Next state and commands
  always_comb begin
    state_d  = state_q;
    cnt_d    = cnt_q;
    ovalid_d = ovalid_q;
    cmd_o    = '0;
    if (ovalid_q && out_ready_i) begin
      ovalid_d = 1'b0;
    end
    unique case (state_q)
      StIdle: begin
        if (in_valid_i) begin
          cmd_o.load_in = 1'b1;
          state_d       = StPrepPos;
        end
      end
      StPrepPos: begin
        cmd_o.prep_pos = 1'b1;
        state_d        = StPrepLen;
      end
      StPrepLen: begin
        cmd_o.prep_len = 1'b1;
        cnt_d          = '0;
        state_d        = StDiv;
      end
      StDiv: begin
        cmd_o.div_step = 1'b1;
        cnt_d          = cnt_q + 1'b1;
        if (cnt_q == DivLast) begin
          state_d = StMul;
        end
      end
      StMul: begin
        cmd_o.mul_frac = 1'b1;
        state_d        = StFinish;
      end
      StFinish: begin
        // hold until the output register is free
        if (out_free) begin
          cmd_o.load_out = 1'b1;
          ovalid_d       = 1'b1;
          state_d        = StIdle;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= StIdle;
      cnt_q    <= '0;
      ovalid_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      cnt_q    <= cnt_d;
      ovalid_q <= ovalid_d;
    end
  end

endmodule

@@ sv/svf_datapath.sv @@
// Config registers, frame position, serial fade divider, gain multipliers and saturation.
`timescale 1ns / 1ps

module svf_datapath (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  svf_pkg::svf_cmd_t                  cmd_i,
  input  logic                               cfg_we_i,
  input  logic [svf_pkg::CfgIdxW-1:0]        cfg_idx_i,
  input  logic [svf_pkg::CfgW-1:0]           cfg_data_i,
  input  logic signed [svf_pkg::SampleW-1:0] left_sample_i,
  input  logic signed [svf_pkg::SampleW-1:0] right_sample_i,
  output logic signed [svf_pkg::SampleW-1:0] left_out_o,
  output logic signed [svf_pkg::SampleW-1:0] right_out_o,
  output logic                               fading_o,
  output logic                               past_end_o
);

  localparam int unsigned SW    = svf_pkg::SampleW;
  localparam int unsigned PW    = svf_pkg::PosW;
  localparam int unsigned FW    = svf_pkg::FracW;
  localparam int unsigned P1W   = SW + svf_pkg::VolW;
  localparam int unsigned P2W   = P1W + FW + 1;
  localparam int unsigned Shift = 28;
  localparam int unsigned MagW  = P2W - Shift;

  localparam logic [svf_pkg::VolW-1:0] VolReset = svf_pkg::VolW'(4096);
  localparam logic [PW-1:0]            PosMax   = '1;
  localparam logic [FW:0]              FracOne  = (FW+1)'(1) << FW;
  localparam logic [MagW-1:0]          PosLimit = MagW'(32767);
  localparam logic [MagW-1:0]          NegLimit = MagW'(32768);

  // Magnitude of a signed sample; the most negative value maps to 2^(SW-1)
  function automatic logic [SW-1:0] mag_of(input logic signed [SW-1:0] s);
    logic [SW-1:0] m;
    m = s[SW-1] ? (~s + 1'b1) : s;
    return m;
  endfunction

  // Signed saturation of a truncated magnitude
  function automatic logic [SW-1:0] sat_of(input logic neg, input logic [MagW-1:0] p);
    logic [SW-1:0] r;
    if (neg) begin
      r = (p > NegLimit) ? {1'b1, {(SW-1){1'b0}}} : (~p[SW-1:0] + 1'b1);
    end else begin
      r = (p > PosLimit) ? {1'b0, {(SW-1){1'b1}}} : p[SW-1:0];
    end
    return r;
  endfunction

  logic [svf_pkg::VolW-1:0] vol_q;
  logic [PW-1:0]            fstart_q, total_q, pos_q;
  logic                     loop_q;

  logic signed [SW-1:0] lsamp_q, rsamp_q;
  logic                 lneg_q, rneg_q;
  logic [P1W-1:0]       lp1_q, rp1_q;
  logic [P2W-1:0]       lp2_q, rp2_q;
  logic                 past_q, fade_q;
  logic [PW-1:0]        len_q, rem_q;
  logic [FW-1:0]        quo_q;

  logic [PW:0]          len_ext, rem_sh, rem_sub;
  logic [FW:0]          frac;

  logic signed [SW-1:0] lout_q, rout_q;
  logic                 fading_q, pend_q;

  // Configuration registers and frame position
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vol_q    <= VolReset;
      fstart_q <= '0;
      total_q  <= '0;
      loop_q   <= 1'b0;
      pos_q    <= '0;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          svf_pkg::RegVolume:    vol_q    <= cfg_data_i[svf_pkg::VolW-1:0];
          svf_pkg::RegFadeStart: fstart_q <= cfg_data_i[PW-1:0];
          svf_pkg::RegTotal:     total_q  <= cfg_data_i[PW-1:0];
          svf_pkg::RegLoop:      loop_q   <= cfg_data_i[0];
          default: ;
        endcase
      end
      if (cmd_i.prep_len && (pos_q != PosMax)) begin
        pos_q <= pos_q + 1'b1;
      end
    end
  end

  // One restoring division step: remainder stays below the fade length
  assign len_ext = {1'b0, len_q};
  assign rem_sh  = {rem_q, 1'b0};
  assign rem_sub = rem_sh - len_ext;
  assign frac    = fade_q ? {1'b0, quo_q} : FracOne;

  // Working registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_in) begin
      lsamp_q <= left_sample_i;
      rsamp_q <= right_sample_i;
    end
    if (cmd_i.prep_pos) begin
      past_q <= !loop_q && (pos_q >= total_q);
      rem_q  <= total_q - pos_q;
      lneg_q <= lsamp_q[SW-1];
      rneg_q <= rsamp_q[SW-1];
      lp1_q  <= mag_of(lsamp_q) * vol_q;
      rp1_q  <= mag_of(rsamp_q) * vol_q;
    end
    if (cmd_i.prep_len) begin
      len_q  <= total_q - fstart_q;
      fade_q <= !loop_q && !past_q && (total_q > fstart_q) && (pos_q > fstart_q);
    end
    if (cmd_i.div_step) begin
      if (rem_sh >= len_ext) begin
        rem_q <= rem_sub[PW-1:0];
        quo_q <= {quo_q[FW-2:0], 1'b1};
      end else begin
        rem_q <= rem_sh[PW-1:0];
        quo_q <= {quo_q[FW-2:0], 1'b0};
      end
    end
    if (cmd_i.mul_frac) begin
      lp2_q <= lp1_q * frac;
      rp2_q <= rp1_q * frac;
    end
    if (cmd_i.load_out) begin
      if (past_q) begin
        lout_q <= '0;
        rout_q <= '0;
      end else begin
        lout_q <= sat_of(lneg_q, lp2_q[P2W-1:Shift]);
        rout_q <= sat_of(rneg_q, rp2_q[P2W-1:Shift]);
      end
      fading_q <= fade_q;
      pend_q   <= past_q;
    end
  end

  assign left_out_o  = lout_q;
  assign right_out_o = rout_q;
  assign fading_o    = fading_q;
  assign past_end_o  = pend_q;

endmodule

@@ sv/stereo_volume_fade_out.sv @@
// Stereo volume and linear fade-out stage, top level.
`timescale 1ns / 1ps

// Scales each stereo frame by the Q4.12 volume and, past the fade start, by a
// Q0.16 linear fade fraction; results truncate toward zero and saturate to 16
// bits. Frames are processed one at a time, in these steps: the request
// cycle, the position and length setup states, a serial divider for the fade
// fraction that yields one quotient bit per cycle, and the multiply and saturate
// states. The input is ready again in the cycle the result appears, so a frame
// is taken only once the previous one is through. The result waits in an output
// register, so the next request is accepted while it is still unclaimed; that
// next frame then holds in its last step until the register is claimed. Frames
// at or past total_frames (unless loop_forever is set) come out as zero with
// past_end set; position counts frames since reset and saturates at 2^40 - 1.
module stereo_volume_fade_out (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [svf_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  logic [svf_pkg::CfgW-1:0]      cfg_data_i,
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  input  logic [2*svf_pkg::SampleW-1:0] s_axis_tdata,  // left_sample, right_sample
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  output logic [2*svf_pkg::SampleW-1:0] m_axis_tdata,  // left_out, right_out
  output logic [1:0]                    m_axis_tuser   // fading, past_end
);

  localparam int unsigned SW = svf_pkg::SampleW;

  svf_pkg::svf_cmd_t cmd;
  logic signed [SW-1:0] left_out, right_out;
  logic fading, past_end;

  svf_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .cmd_o       (cmd)
  );

  svf_datapath u_datapath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .cfg_we_i       (cfg_we_i),
    .cfg_idx_i      (cfg_idx_i),
    .cfg_data_i     (cfg_data_i),
    .left_sample_i  (s_axis_tdata[SW-1:0]),
    .right_sample_i (s_axis_tdata[2*SW-1:SW]),
    .left_out_o     (left_out),
    .right_out_o    (right_out),
    .fading_o       (fading),
    .past_end_o     (past_end)
  );

  assign m_axis_tdata = {right_out, left_out};
  assign m_axis_tuser = {past_end, fading};

  // A request keeps the block busy for the next cycle
  a_busy_after_req : assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("input ready right after a request");

  // A frame is never both fading and past the end
  a_flags_exclusive : assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> !(m_axis_tuser[0] && m_axis_tuser[1]))
    else $error("fading and past_end both set");

  // Past the end the samples are silent
  a_past_silent : assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser[1] |-> m_axis_tdata == '0)
    else $error("nonzero output past the end");

endmodule
